// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion macros shared by the cipher core RTL. The macros use the
// module's clk and arst_n, and compile to nothing under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge outside reset
`define BF_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("blowfish core assertion failed");
// Check that a condition never holds outside reset
`define BF_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("blowfish core forbidden condition seen");
`else
`define BF_ASSERT(lbl, prop)
`define BF_NEVER(lbl, expr)
`endif

`endif

// ===== sv/bf_pkg.sv =====
// ----------------------------------------------------------------------------
// bf_pkg
// Constants, types and the pi seed table of the Blowfish cipher core.
// ----------------------------------------------------------------------------
package bf_pkg;

	localparam int ROUNDS      = 16;
	localparam int NSUB        = ROUNDS + 2;
	localparam int RND_W       = $clog2(ROUNDS);
	localparam int P_AW        = $clog2(NSUB);
	localparam int SBOX_DEPTH  = 256;
	localparam int SBOX_TOTAL  = 4 * SBOX_DEPTH;
	localparam int MIX_BYTES   = 4 * NSUB;
	localparam int MIX_W       = $clog2(MIX_BYTES);
	localparam int FILL_PAIRS  = (NSUB + SBOX_TOTAL) / 2;
	localparam int FILL_W      = $clog2(FILL_PAIRS);
	localparam logic [31:0] SEED_MUL = 32'h9E3779B9;

	// Operation codes
	localparam logic [1:0] OP_KEY  = 2'd0;
	localparam logic [1:0] OP_ENC  = 2'd1;
	localparam logic [1:0] OP_DEC  = 2'd2;

	// Result kinds
	localparam logic RK_BLOCK = 1'b0;
	localparam logic RK_KEY   = 1'b1;

	// Command from the sequencer to the cipher engine
	typedef struct packed {
		logic             start;
		logic             decrypt;
		logic [63:0]      block;
		logic             p_we;
		logic             p_xor;
		logic [P_AW-1:0]  p_addr;
		logic [31:0]      p_wdata;
		logic [3:0]       s_we;
		logic [7:0]       s_addr;
		logic [3:0][31:0] s_wdata;
		logic             seeded;
	} eng_cmd_t;

	// Status from the cipher engine
	typedef struct packed {
		logic        done;
		logic [63:0] block;
	} eng_sts_t;

	// Fraction digits of pi that seed the subkeys and the S boxes
	function automatic logic [31:0] pi_word(input logic [P_AW-1:0] idx);
		logic [31:0] w;
		case (idx)
			5'd0:    w = 32'h243f6a88;
			5'd1:    w = 32'h85a308d3;
			5'd2:    w = 32'h13198a2e;
			5'd3:    w = 32'h03707344;
			5'd4:    w = 32'ha4093822;
			5'd5:    w = 32'h299f31d0;
			5'd6:    w = 32'h082efa98;
			5'd7:    w = 32'hec4e6c89;
			5'd8:    w = 32'h452821e6;
			5'd9:    w = 32'h38d01377;
			5'd10:   w = 32'hbe5466cf;
			5'd11:   w = 32'h34e90c6c;
			5'd12:   w = 32'hc0ac29b7;
			5'd13:   w = 32'hc97c50dd;
			5'd14:   w = 32'h3f84d5b5;
			5'd15:   w = 32'hb5470917;
			5'd16:   w = 32'h9216d5d9;
			5'd17:   w = 32'h8979fb1b;
			default: w = 32'h0;
		endcase
		return w;
	endfunction

endpackage

// ===== sv/bf_engine.sv =====
// ----------------------------------------------------------------------------
// bf_engine
// Holds the subkeys and the four S boxes and runs each Feistel round in two
// steps (E_RA, E_RB) through a shared round unit, then the two whitening steps.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bf_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  bf_pkg::eng_cmd_t  cmd,
	output bf_pkg::eng_sts_t  sts
);
	import bf_pkg::*;

	typedef enum logic [4:0] {
		E_IDLE = 5'b00001,
		E_RA   = 5'b00010,
		E_RB   = 5'b00100,
		E_W1   = 5'b01000,
		E_W2   = 5'b10000
	} est_t;

	est_t             st_q;
	logic [RND_W-1:0] rnd_q;
	logic             dec_q;
	logic             done_q;
	logic             seeded_q;
	logic [31:0]      l_q, r_q;
	logic [31:0]      p_q [NSUB];
	logic [3:0][31:0] sd_q;
	logic [3:0][7:0]  rd_addr;
	logic [P_AW-1:0]  p_idx;
	logic [31:0]      p_rd, lx, f;
	logic [3:0][31:0] sv;
	logic [31:0]      sbox_mem [4][SBOX_DEPTH];

	// Pick the subkey for this step
	always_comb begin
		case (st_q)
			E_W1:    p_idx = dec_q ? P_AW'(0) : P_AW'(NSUB - 1);
			E_W2:    p_idx = dec_q ? P_AW'(1) : P_AW'(ROUNDS);
			default: p_idx = dec_q ? (P_AW'(NSUB - 1) - P_AW'(rnd_q)) : P_AW'(rnd_q);
		endcase
	end

	assign p_rd = p_q[p_idx];
	assign lx   = l_q ^ p_rd;

	// Round function on the registered S box data; unseeded boxes read zero
	always_comb begin
		for (int b = 0; b < 4; b++) begin
			rd_addr[b] = lx[8*(3-b) +: 8];
			sv[b]      = seeded_q ? sd_q[b] : 32'h0;
		end
		f = ((sv[0] + sv[1]) ^ sv[2]) + sv[3];
	end

	// S box memories, one write and one read port each
	always_ff @(posedge clk) begin
		for (int b = 0; b < 4; b++) begin
			if (cmd.s_we[b]) begin
				sbox_mem[b][cmd.s_addr] <= cmd.s_wdata[b];
			end
			sd_q[b] <= sbox_mem[b][rd_addr[b]];
		end
	end

	// Sequence rounds and hold subkeys
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= E_IDLE;
			rnd_q    <= '0;
			done_q   <= 1'b0;
			seeded_q <= 1'b0;
			for (int i = 0; i < NSUB; i++) begin
				p_q[i] <= '0;
			end
		end else begin
			done_q <= 1'b0;
			if (cmd.seeded) begin
				seeded_q <= 1'b1;
			end
			if (cmd.p_we) begin
				p_q[cmd.p_addr] <= cmd.p_xor ? (p_q[cmd.p_addr] ^ cmd.p_wdata) : cmd.p_wdata;
			end
			case (st_q)
				E_IDLE: begin
					if (cmd.start) begin
						rnd_q <= '0;
						st_q  <= E_RA;
					end
				end
				E_RA: st_q <= E_RB;
				E_RB: begin
					if (rnd_q == RND_W'(ROUNDS - 1)) begin
						st_q <= E_W1;
					end else begin
						rnd_q <= rnd_q + 1'b1;
						st_q  <= E_RA;
					end
				end
				E_W1: st_q <= E_W2;
				E_W2: begin
					done_q <= 1'b1;
					st_q   <= E_IDLE;
				end
				default: st_q <= E_IDLE;
			endcase
		end
	end

	// Advance the block halves
	always_ff @(posedge clk) begin
		case (st_q)
			E_IDLE: begin
				if (cmd.start) begin
					l_q   <= cmd.block[63:32];
					r_q   <= cmd.block[31:0];
					dec_q <= cmd.decrypt;
				end
			end
			E_RA: l_q <= lx;
			E_RB: begin
				l_q <= r_q ^ f;
				r_q <= l_q;
			end
			E_W1: begin
				l_q <= r_q ^ p_rd;
				r_q <= l_q;
			end
			E_W2: r_q <= r_q ^ p_rd;
			default: l_q <= l_q;
		endcase
	end

	assign sts.done  = done_q;
	assign sts.block = {l_q, r_q};

	`BF_ASSERT(a_start_idle, cmd.start |-> st_q == E_IDLE)
	`BF_ASSERT(a_done_after_w2, done_q |-> $past(st_q == E_W2))
	`BF_NEVER(a_write_busy, (cmd.p_we || cmd.s_we != 4'h0) && st_q != E_IDLE)

endmodule

// ===== sv/blowfish_cipher_core_unit.sv =====
// ----------------------------------------------------------------------------
// blowfish_cipher_core_unit
// Blowfish engine with on-board key schedule: key bytes, then encrypt and
// decrypt requests on one input channel; one result per block or key.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid/in_ready    operation key_byte key_last block_in
//   out      source     out_valid/out_ready  result_kind block_out
//
// A block request runs each round in two steps in the shared round unit
// (the S box read is registered), then two whitening steps and hand-over.
// The last key byte starts the schedule: S box seeding, key mixing, then
// 521 chained encryptions. Reset clears subkeys and marks the S boxes
// unseeded, so they read as zero. A result waiting in the output register
// does not block the input; a second finished result holds the core until
// it drains.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module blowfish_cipher_core_unit #(
	parameter int MAX_KEY_BYTES = 72
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [7:0]  key_byte,
	input  logic        key_last,
	input  logic [63:0] block_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        result_kind,
	output logic [63:0] block_out
);
	import bf_pkg::*;

	localparam int KC_W = $clog2(MAX_KEY_BYTES + 1);
	localparam int KA_W = $clog2(MAX_KEY_BYTES);

	typedef enum logic [7:0] {
		T_IDLE  = 8'b00000001,
		T_SEED  = 8'b00000010,
		T_MIX   = 8'b00000100,
		T_KENC  = 8'b00001000,
		T_KWAIT = 8'b00010000,
		T_PUTL  = 8'b00100000,
		T_PUTR  = 8'b01000000,
		T_BWAIT = 8'b10000000
	} tst_t;

	tst_t              st_q;
	logic [KC_W-1:0]   kcnt_q, len_q;
	logic [KA_W-1:0]   j_q;
	logic [MIX_W-1:0]  n_q;
	logic              ph_q;
	logic [23:0]       k_q;
	logic [7:0]        kb_q;
	logic [7:0]        b_q;
	logic [3:0][P_AW-1:0] m_q;
	logic [31:0]       acc_q;
	logic [FILL_W-1:0] w_q;
	logic              out_valid_q, kind_q;
	logic              fin_q;
	logic [63:0]       blk_q;
	logic [7:0]        kbuf [MAX_KEY_BYTES];
	logic              acc_in, room;
	logic              out_free, fill_last, blk_fire, key_fire;
	logic [31:0]       put_data;
	logic [9:0]        sidx;
	eng_cmd_t          cmd;
	eng_sts_t          sts;

	assign in_ready    = (st_q == T_IDLE);
	assign acc_in      = in_valid && in_ready;
	assign room        = kcnt_q < KC_W'(MAX_KEY_BYTES);
	assign out_valid   = out_valid_q;
	assign result_kind = kind_q;
	assign block_out   = blk_q;

	// Result hand-over to the output register
	assign out_free  = !out_valid_q || out_ready;
	assign fill_last = (st_q == T_PUTR) && (w_q == FILL_W'(FILL_PAIRS - 1));
	assign blk_fire  = (st_q == T_BWAIT) && (sts.done || fin_q) && out_free;
	assign key_fire  = fill_last && out_free;

	// Key buffer memory
	always_ff @(posedge clk) begin
		if (acc_in && operation == OP_KEY && room) begin
			kbuf[kcnt_q[KA_W-1:0]] <= key_byte;
		end
		kb_q <= kbuf[j_q];
	end

	assign put_data = (st_q == T_PUTL) ? sts.block[63:32] : sts.block[31:0];
	assign sidx     = {9'(w_q - FILL_W'(NSUB / 2)), (st_q == T_PUTR)};

	// Build engine commands
	always_comb begin
		cmd = '0;
		case (st_q)
			T_IDLE: begin
				if (acc_in && (operation == OP_ENC || operation == OP_DEC)) begin
					cmd.start   = 1'b1;
					cmd.decrypt = (operation == OP_DEC);
					cmd.block   = block_in;
				end
			end
			T_SEED: begin
				cmd.s_we   = 4'hF;
				cmd.s_addr = b_q;
				for (int k = 0; k < 4; k++) begin
					cmd.s_wdata[k] = pi_word(m_q[k]) ^ acc_q;
				end
				if (b_q < 8'(NSUB)) begin
					cmd.p_we    = 1'b1;
					cmd.p_addr  = b_q[P_AW-1:0];
					cmd.p_wdata = pi_word(b_q[P_AW-1:0]);
				end
				cmd.seeded = (b_q == 8'(SBOX_DEPTH - 1));
			end
			T_MIX: begin
				if (ph_q && n_q[1:0] == 2'b11) begin
					cmd.p_we    = 1'b1;
					cmd.p_xor   = 1'b1;
					cmd.p_addr  = n_q[MIX_W-1:2];
					cmd.p_wdata = {k_q, kb_q};
				end
			end
			T_KENC: begin
				cmd.start = 1'b1;
				cmd.block = (w_q == '0) ? 64'h0 : sts.block;
			end
			T_PUTL, T_PUTR: begin
				if (w_q < FILL_W'(NSUB / 2)) begin
					cmd.p_we    = 1'b1;
					cmd.p_addr  = {w_q[P_AW-2:0], (st_q == T_PUTR)};
					cmd.p_wdata = put_data;
				end else begin
					cmd.s_we   = 4'b0001 << sidx[9:8];
					cmd.s_addr = sidx[7:0];
					for (int k = 0; k < 4; k++) begin
						cmd.s_wdata[k] = put_data;
					end
				end
			end
			default: cmd = '0;
		endcase
	end

	// Sequence requests and the key schedule
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= T_IDLE;
			kcnt_q      <= '0;
			len_q       <= '0;
			j_q         <= '0;
			n_q         <= '0;
			ph_q        <= 1'b0;
			b_q         <= '0;
			m_q         <= '0;
			acc_q       <= '0;
			w_q         <= '0;
			out_valid_q <= 1'b0;
			fin_q       <= 1'b0;
			kind_q      <= RK_BLOCK;
		end else begin
			if (blk_fire || key_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				T_IDLE: begin
					if (acc_in) begin
						case (operation)
							OP_KEY: begin
								if (room) begin
									kcnt_q <= kcnt_q + 1'b1;
								end
								if (key_last) begin
									len_q <= kcnt_q + KC_W'(room);
									b_q   <= '0;
									acc_q <= '0;
									for (int k = 0; k < 4; k++) begin
										m_q[k] <= P_AW'((k * SBOX_DEPTH) % NSUB);
									end
									st_q <= T_SEED;
								end
							end
							OP_ENC, OP_DEC: st_q <= T_BWAIT;
							default: st_q <= T_IDLE;
						endcase
					end
				end
				T_SEED: begin
					b_q   <= b_q + 1'b1;
					acc_q <= acc_q + SEED_MUL;
					for (int k = 0; k < 4; k++) begin
						m_q[k] <= (m_q[k] == P_AW'(NSUB - 1)) ? '0 : m_q[k] + 1'b1;
					end
					if (b_q == 8'(SBOX_DEPTH - 1)) begin
						n_q  <= '0;
						ph_q <= 1'b0;
						j_q  <= '0;
						st_q <= T_MIX;
					end
				end
				T_MIX: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						k_q <= {k_q[15:0], kb_q};
						j_q <= (KC_W'(j_q) + KC_W'(1) == len_q) ? '0 : j_q + 1'b1;
						n_q <= n_q + 1'b1;
						if (n_q == MIX_W'(MIX_BYTES - 1)) begin
							w_q  <= '0;
							st_q <= T_KENC;
						end
					end
				end
				T_KENC: st_q <= T_KWAIT;
				T_KWAIT: begin
					if (sts.done) begin
						st_q <= T_PUTL;
					end
				end
				T_PUTL: st_q <= T_PUTR;
				T_PUTR: begin
					if (fill_last) begin
						// hold the last pair until the output register frees up
						if (out_free) begin
							kcnt_q <= '0;
							kind_q <= RK_KEY;
							st_q   <= T_IDLE;
						end
					end else begin
						w_q  <= w_q + 1'b1;
						st_q <= T_KENC;
					end
				end
				T_BWAIT: begin
					if (blk_fire) begin
						fin_q  <= 1'b0;
						kind_q <= RK_BLOCK;
						st_q   <= T_IDLE;
					end else if (sts.done) begin
						fin_q <= 1'b1;
					end
				end
				default: st_q <= T_IDLE;
			endcase
		end
	end

	// Hold the result block
	always_ff @(posedge clk) begin
		if (blk_fire) begin
			blk_q <= sts.block;
		end else if (key_fire) begin
			blk_q <= 64'h0;
		end
	end

	bf_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts)
	);

	`BF_ASSERT(a_done_in_wait, sts.done |-> (st_q == T_KWAIT || st_q == T_BWAIT))
	`BF_ASSERT(a_kcnt_range, kcnt_q <= KC_W'(MAX_KEY_BYTES))
	`BF_ASSERT(a_key_result, key_fire |=> (out_valid && result_kind == RK_KEY))

endmodule

// ===== tb/blowfish_cipher_core_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Blowfish cipher core testbench
// Drives key loads, encrypt and decrypt requests with random gaps and output
// stalls, predicts every result with a local cipher and key schedule model,
// and compares each result field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module blowfish_cipher_core_unit_tb;
	import bf_pkg::*;

	localparam int KEY_MAX    = 72;
	localparam int IDLE_LIMIT = 200000;
	localparam logic [1:0] OP_NONE = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  operation;
	logic [7:0]  key_byte;
	logic        key_last;
	logic [63:0] block_in;
	logic        out_valid;
	logic        out_ready;
	logic        result_kind;
	logic [63:0] block_out;

	typedef struct {
		logic        kind;
		logic [63:0] blk;
	} cipher_result_t;

	// One directed row: a request, and optionally a typed-in answer
	typedef struct {
		logic [1:0]  op;
		logic [7:0]  kb;
		logic        kl;
		logic [63:0] blk;
		logic        fixed;
		logic [63:0] answer;
	} bf_row_t;

	// Local copy of the cipher state
	logic [31:0] subkeys [NSUB];
	logic [31:0] sboxes [SBOX_TOTAL];
	logic [7:0]  key_bytes [KEY_MAX];
	int          key_len;

	cipher_result_t pending_results[$];
	int  fail_count;
	int  idle_cycles;
	bit  hold_off;

	blowfish_cipher_core_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .key_byte(key_byte), .key_last(key_last),
		.block_in(block_in),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_kind(result_kind), .block_out(block_out)
	);

	always #5 clk = ~clk;

	function automatic logic [31:0] feistel_f(logic [31:0] x);
		logic [31:0] y;
		y = sboxes[x[31:24]] + sboxes[256 + x[23:16]];
		y ^= sboxes[512 + x[15:8]];
		return y + sboxes[768 + x[7:0]];
	endfunction

	function automatic logic [63:0] cipher_block(logic [63:0] blk, bit dec);
		logic [31:0] l, r, t;
		int idx;
		l = blk[63:32];
		r = blk[31:0];
		for (int i = 0; i < ROUNDS; i++) begin
			idx = dec ? (NSUB - 1 - i) : i;
			l ^= subkeys[idx];
			r ^= feistel_f(l);
			t = l; l = r; r = t;
		end
		t = l; l = r; r = t;
		if (dec) begin
			r ^= subkeys[1];
			l ^= subkeys[0];
		end else begin
			r ^= subkeys[ROUNDS];
			l ^= subkeys[ROUNDS + 1];
		end
		return {l, r};
	endfunction

	function automatic logic [31:0] pi_seed_word(int i);
		logic [31:0] seed [NSUB] = '{
			32'h243f6a88, 32'h85a308d3, 32'h13198a2e, 32'h03707344, 32'ha4093822,
			32'h299f31d0, 32'h082efa98, 32'hec4e6c89, 32'h452821e6, 32'h38d01377,
			32'hbe5466cf, 32'h34e90c6c, 32'hc0ac29b7, 32'hc97c50dd, 32'h3f84d5b5,
			32'hb5470917, 32'h9216d5d9, 32'h8979fb1b};
		return seed[i];
	endfunction

	// Seed tables, mix in the key, then refill with chained encryptions
	task automatic expand_key();
		logic [31:0] k;
		logic [63:0] d;
		int j;
		for (int i = 0; i < NSUB; i++) subkeys[i] = pi_seed_word(i);
		for (int i = 0; i < SBOX_TOTAL; i++)
			sboxes[i] = pi_seed_word(i % NSUB) ^ (32'(i & 255) * SEED_MUL);
		j = 0;
		for (int i = 0; i < NSUB; i++) begin
			k = '0;
			for (int t = 0; t < 4; t++) begin
				k = {k[23:0], key_bytes[j]};
				j = (j + 1) % key_len;
			end
			subkeys[i] ^= k;
		end
		d = '0;
		for (int i = 0; i < NSUB; i += 2) begin
			d = cipher_block(d, 0);
			subkeys[i] = d[63:32];
			subkeys[i + 1] = d[31:0];
		end
		for (int i = 0; i < SBOX_TOTAL; i += 2) begin
			d = cipher_block(d, 0);
			sboxes[i] = d[63:32];
			sboxes[i + 1] = d[31:0];
		end
	endtask

	// Predict the outcome of one accepted request
	task automatic predict_request(logic [1:0] op, logic [7:0] kb, logic kl,
			logic [63:0] blk);
		cipher_result_t res;
		if (op == OP_KEY) begin
			if (key_len < KEY_MAX) begin
				key_bytes[key_len] = kb;
				key_len++;
			end
			if (kl) begin
				expand_key();
				key_len = 0;
				res.kind = RK_KEY;
				res.blk = '0;
				pending_results.push_back(res);
			end
		end else if (op != OP_NONE) begin
			res.kind = RK_BLOCK;
			res.blk = cipher_block(blk, op == OP_DEC);
			pending_results.push_back(res);
		end
	endtask

	// Offer one request and hold it until accepted; valid drops only in a gap
	task automatic send_request(logic [1:0] op, logic [7:0] kb, logic kl,
			logic [63:0] blk);
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		key_byte <= kb;
		key_last <= kl;
		block_in <= blk;
		do @(posedge clk); while (!in_ready);
		predict_request(op, kb, kl, blk);
	endtask

	task automatic load_key(int len);
		for (int i = 0; i < len; i++)
			send_request(OP_KEY, 8'($urandom), i == len - 1, 64'({$urandom, $urandom}));
	endtask

	function automatic logic [63:0] rand_block();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Check each accepted result against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result kind=%0d block=%h", result_kind, block_out);
				fail_count++;
			end else begin
				cipher_result_t exp_res;
				exp_res = pending_results.pop_front();
				if (result_kind !== exp_res.kind) begin
					$error("result_kind expected %0d actual %0d", exp_res.kind, result_kind);
					fail_count++;
				end
				if (block_out !== exp_res.blk) begin
					$error("block_out expected %h actual %h", exp_res.blk, block_out);
					fail_count++;
				end
			end
		end
	end

	// Receiver stalls, with one long hold-off on request
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_off) begin
			out_ready <= 1'b0;
		end else if ($urandom_range(0, 99) < 3) begin
			out_ready <= 1'b0;
		end else if (!out_ready && $urandom_range(0, 2) != 0) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 0);
		end
	end

	// Watchdog on cycles with no handshake
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAIL blowfish_cipher_core_unit");
				$finish;
			end
		end
	end

	bf_row_t rows[$];
	logic [63:0] blk_a;

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_KEY;
		key_byte = '0;
		key_last = 1'b0;
		block_in = '0;
		fail_count = 0;
		idle_cycles = 0;
		hold_off = 0;
		key_len = 0;
		for (int i = 0; i < NSUB; i++) subkeys[i] = '0;
		for (int i = 0; i < SBOX_TOTAL; i++) sboxes[i] = '0;
		for (int i = 0; i < KEY_MAX; i++) key_bytes[i] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows: zero tables give obvious answers after reset
		rows = '{
			'{OP_ENC,  8'h00, 1'b0, 64'h0, 1'b1, 64'h0},
			'{OP_DEC,  8'hff, 1'b1, 64'hffffffffffffffff, 1'b1, 64'hffffffffffffffff},
			'{OP_NONE, 8'h00, 1'b1, 64'h0, 1'b0, 64'h0},
			'{OP_ENC,  8'h00, 1'b0, 64'h0123456789abcdef, 1'b1, 64'h89abcdef01234567},
			'{OP_KEY,  8'h00, 1'b0, 64'hffffffffffffffff, 1'b0, 64'h0},
			'{OP_KEY,  8'hff, 1'b0, 64'h0, 1'b0, 64'h0},
			'{OP_KEY,  8'h5a, 1'b1, 64'h0, 1'b1, 64'h0},
			'{OP_ENC,  8'hff, 1'b1, 64'h0, 1'b0, 64'h0},
			'{OP_ENC,  8'h00, 1'b0, 64'hffffffffffffffff, 1'b0, 64'h0},
			'{OP_DEC,  8'h00, 1'b0, 64'h0, 1'b0, 64'h0},
			'{OP_DEC,  8'h00, 1'b0, 64'hffffffff00000000, 1'b0, 64'h0},
			'{OP_NONE, 8'hff, 1'b0, 64'hffffffffffffffff, 1'b0, 64'h0},
			'{OP_KEY,  8'h80, 1'b1, 64'h0, 1'b1, 64'h0}
		};
		foreach (rows[i]) begin
			send_request(rows[i].op, rows[i].kb, rows[i].kl, rows[i].blk);
			if (rows[i].fixed && pending_results.size() > 0 &&
					pending_results[$].blk !== rows[i].answer) begin
				$error("block_out expected %h actual %h (predictor)",
					rows[i].answer, pending_results[$].blk);
				fail_count++;
			end
		end

		// Overlong key: bytes past the buffer are dropped
		load_key(80);
		// Longest stored key, then an encrypt and decrypt round trip
		load_key(KEY_MAX);
		blk_a = rand_block();
		send_request(OP_ENC, 8'h00, 1'b0, blk_a);
		send_request(OP_DEC, 8'h00, 1'b0, pending_results[$].blk);

		// Long receiver hold-off while requests keep coming
		fork
			begin
				hold_off = 1;
				repeat (400) @(posedge clk);
				hold_off = 0;
			end
			for (int i = 0; i < 12; i++)
				send_request(OP_ENC, 8'($urandom), 1'($urandom), rand_block());
		join

		// Random part: mostly blocks, an occasional fresh key
		for (int n = 0; n < 1500; n++) begin
			int pick;
			pick = $urandom_range(0, 199);
			if (pick == 0) begin
				load_key(($urandom_range(0, 3) == 0) ? $urandom_range(60, 75)
					: $urandom_range(1, 16));
			end else if (pick < 4) begin
				send_request(OP_NONE, 8'($urandom), 1'($urandom), rand_block());
			end else begin
				send_request(($urandom_range(0, 1) == 0) ? OP_ENC : OP_DEC,
					8'($urandom), 1'($urandom), rand_block());
			end
		end
		in_valid <= 1'b0;

		while (pending_results.size() > 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0) begin
			$display("PASS blowfish_cipher_core_unit");
		end else begin
			$display("FAIL blowfish_cipher_core_unit");
		end
		$finish;
	end

endmodule
